// File: src/aging_score_task_scheduler_top_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef AGING_SCORE_TASK_SCHEDULER_TOP_ASSERT_SVH
`define AGING_SCORE_TASK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define ASTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/asts_pkg.sv
`default_nettype none
package asts_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  // opcodes
  localparam logic [3:0] OP_CREATE   = 4'd0;
  localparam logic [3:0] OP_START    = 4'd1;
  localparam logic [3:0] OP_PICK     = 4'd2;
  localparam logic [3:0] OP_RUN_END  = 4'd3;
  localparam logic [3:0] OP_WAKE     = 4'd4;
  localparam logic [3:0] OP_FREEZE   = 4'd5;
  localparam logic [3:0] OP_UNFREEZE = 4'd6;
  localparam logic [3:0] OP_KILL     = 4'd7;
  localparam logic [3:0] OP_FREE     = 4'd8;

  // result status
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_NONE     = 3'd2;
  localparam logic [2:0] STS_NO_PID   = 3'd3;
  localparam logic [2:0] STS_BAD_SLOT = 3'd4;

  // entry states
  localparam logic [2:0] TS_UNUSED = 3'd0;
  localparam logic [2:0] TS_DEFER  = 3'd1;
  localparam logic [2:0] TS_SLEEP  = 3'd2;
  localparam logic [2:0] TS_READY  = 3'd3;
  localparam logic [2:0] TS_RUN    = 3'd4;
  localparam logic [2:0] TS_DONE   = 3'd5;

  // flag bits
  localparam int unsigned FL_DEFER  = 0;
  localparam int unsigned FL_FROZEN = 1;
  localparam int unsigned FL_KILLED = 2;
  localparam int unsigned FL_RAN    = 3;

  // run end next state
  localparam logic [1:0] NS_SLEEP = 2'd1;
  localparam logic [1:0] NS_EXIT  = 2'd2;

  // config register indexes
  localparam logic CFG_RUN_WEIGHT  = 1'b0;
  localparam logic CFG_WAIT_WEIGHT = 1'b1;

  localparam logic [30:0] PID_MAX = 31'h7FFF_FFFF;

  // one task table row
  typedef struct packed {
    logic [2:0]  state;
    logic [30:0] pid;
    logic [3:0]  flags;
    logic [31:0] arrival;
    logic [31:0] run_time;
    logic [31:0] last_start;
    logic [31:0] first_run;
    logic [31:0] defer_start;
    logic [30:0] limit;
    logic [30:0] switches;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: src/asts_ram.sv
`default_nettype none
// Simple dual-port RAM, one write and one registered read port.
module asts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: src/aging_score_task_scheduler_top.sv
// Channel   | Direction | Handshake              | Payload
// command   | in        | start_i, busy_o        | opcode_i now_tick_i slot_arg_i pid_arg_i
//           |           |                        | defer_start_i run_limit_i next_state_i
// result    | out       | done_o (one cycle)     | status_o slot_out_o pid_out_o turnaround_o
//           |           |                        | waiting_o response_o switches_o
// config    | in        | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// Create, start deferred, pick, freeze, unfreeze and kill sweep all 64 table rows
// through the single read port of the entry RAM before the result comes out.
// Pick and kill that find a row read it once more and then write its update.
// Run end, wake and free touch one row; unknown opcodes touch none.
// Reset sets control, loads the default weights and clears the per-row valid bits; no clearing pass.
// The result receiver cannot stall; busy_o is already low in the cycle done_o is high.
`default_nettype none
module aging_score_task_scheduler_top
  import asts_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [3:0]         opcode_i,
  input  wire logic [31:0]        now_tick_i,
  input  wire logic [5:0]         slot_arg_i,
  input  wire logic [30:0]        pid_arg_i,
  input  wire logic               defer_start_i,
  input  wire logic [30:0]        run_limit_i,
  input  wire logic [1:0]         next_state_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [5:0]              slot_out_o,
  output logic [30:0]             pid_out_o,
  output logic [31:0]             turnaround_o,
  output logic [31:0]             waiting_o,
  output logic signed [31:0]      response_o,
  output logic [30:0]             switches_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FWR  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic        rv_q, rv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic        vld_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic        found_q, found_d;
  logic [IDX_W-1:0] best_q, best_d, tgt_q, tgt_d;
  logic [31:0] bscore_q, bscore_d;
  logic [31:0] last_q, last_d;
  logic [30:0] npid_q, npid_d;
  logic [7:0]  run_wt_q, wait_wt_q;

  logic [3:0]  op_q;
  logic [31:0] now_q;
  logic [5:0]  slot_q;
  logic [30:0] pidarg_q, limit_q;
  logic        defer_q;
  logic [1:0]  nst_q;

  logic        re, we;
  logic [IDX_W-1:0] raddr, waddr;
  entry_t      rdata_raw, ent, wdata;

  logic        done_d;
  logic [2:0]  status_d;
  logic [5:0]  slot_d;
  logic [30:0] pid_d, sw_d;
  logic [31:0] tat_d, wait_d, resp_d;

  logic        scan_op;
  logic [31:0] w_ticks, score, sc_wait, sc_run, new_run, tat;
  logic        accept;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign scan_op     = (opcode_i == OP_CREATE) || (opcode_i == OP_START) ||
                       (opcode_i == OP_PICK) || (opcode_i == OP_FREEZE) ||
                       (opcode_i == OP_UNFREEZE) || (opcode_i == OP_KILL);

  asts_ram #(.Width(ENTRY_W), .Depth(TABLE_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // rows never written read as the reset row
  assign ent = vld_q ? rdata_raw : '0;

  // aging score of the row on the read port
  assign w_ticks = now_q - ent.arrival - ent.run_time;
  assign sc_wait = w_ticks * {24'd0, wait_wt_q};
  assign sc_run  = ent.run_time * {24'd0, run_wt_q};
  assign score   = sc_wait - sc_run;
  assign new_run = ent.run_time + (now_q - ent.last_start);
  assign tat     = now_q - ent.arrival;

  // sequencer, scan update and final row update
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rv_d     = 1'b0;
    ridx_d   = ridx_q;
    found_d  = found_q;
    best_d   = best_q;
    bscore_d = bscore_q;
    tgt_d    = tgt_q;
    last_d   = last_q;
    npid_d   = npid_q;
    re       = 1'b0;
    raddr    = cnt_q;
    we       = 1'b0;
    waddr    = ridx_q;
    wdata    = ent;
    done_d   = 1'b0;
    status_d = STS_OK;
    slot_d   = '0;
    pid_d    = '0;
    tat_d    = '0;
    wait_d   = '0;
    resp_d   = '0;
    sw_d     = '0;

    // per-row work while sweeping
    if (rv_q) begin
      unique case (op_q)
        OP_CREATE: begin
          if (!found_q && ent.state == TS_UNUSED) begin
            found_d = 1'b1;
            best_d  = ridx_q;
          end
        end
        OP_START: begin
          if (ent.flags[FL_DEFER] && ent.state == TS_DEFER) begin
            wdata.state       = TS_READY;
            wdata.defer_start = now_q;
            we                = 1'b1;
          end
        end
        OP_PICK: begin
          if (ent.state == TS_READY && !ent.flags[FL_FROZEN]) begin
            if (ent.flags[FL_DEFER] && ent.limit != '0 &&
                (now_q - ent.defer_start) >= {1'b0, ent.limit}) begin
              wdata.flags[FL_DEFER] = 1'b0;
              we                    = 1'b1;
            end else if (!found_q || $signed(score) > $signed(bscore_q)) begin
              found_d  = 1'b1;
              best_d   = ridx_q;
              bscore_d = score;
            end
          end
        end
        OP_FREEZE: begin
          if (ent.pid > 31'd2) begin
            wdata.flags[FL_FROZEN] = 1'b1;
            we                     = 1'b1;
          end
        end
        OP_UNFREEZE: begin
          wdata.flags[FL_FROZEN] = 1'b0;
          we                     = 1'b1;
        end
        OP_KILL: begin
          if (!found_q && ent.state != TS_UNUSED && ent.pid == pidarg_q &&
              pidarg_q != '0) begin
            found_d = 1'b1;
            best_d  = ridx_q;
          end
        end
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          found_d = 1'b0;
          cnt_d   = '0;
          state_d = scan_op ? S_SCAN : S_FRD;
        end
      end
      S_SCAN: begin
        re     = 1'b1;
        raddr  = cnt_q;
        rv_d   = 1'b1;
        ridx_d = cnt_q;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_FRD;
      end
      S_FRD: begin
        state_d = S_IDLE;
        priority case (op_q)
          OP_CREATE: begin
            done_d = 1'b1;
            if (found_q) begin
              we                = 1'b1;
              waddr             = best_q;
              wdata             = '0;
              wdata.pid         = npid_q;
              wdata.flags       = {3'b000, defer_q};
              wdata.arrival     = now_q;
              wdata.defer_start = now_q;
              wdata.limit       = limit_q;
              wdata.state       = defer_q ? TS_DEFER : TS_READY;
              npid_d            = (npid_q == PID_MAX) ? 31'd1 : npid_q + 31'd1;
              slot_d            = best_q;
              pid_d             = npid_q;
            end else begin
              status_d = STS_FULL;
            end
          end
          OP_PICK, OP_KILL: begin
            if (found_q) begin
              re      = 1'b1;
              raddr   = best_q;
              tgt_d   = best_q;
              state_d = S_FWR;
            end else begin
              done_d   = 1'b1;
              status_d = (op_q == OP_PICK) ? STS_NONE : STS_NO_PID;
            end
          end
          OP_RUN_END, OP_WAKE, OP_FREE: begin
            re      = 1'b1;
            raddr   = slot_q;
            tgt_d   = slot_q;
            state_d = S_FWR;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      S_FWR: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        waddr   = tgt_q;
        slot_d  = tgt_q;
        pid_d   = ent.pid;
        priority case (op_q)
          OP_PICK: begin
            we = 1'b1;
            if (!ent.flags[FL_RAN]) begin
              wdata.first_run     = tat;
              wdata.flags[FL_RAN] = 1'b1;
            end
            wdata.last_start = now_q;
            if ({1'b0, ent.pid} != last_q && ent.switches != PID_MAX) begin
              wdata.switches = ent.switches + 31'd1;
            end
            if (ent.pid != 31'd1 && ent.pid != 31'd2) begin
              last_d = {1'b0, ent.pid};
            end
            wdata.state = TS_RUN;
          end
          OP_KILL: begin
            we                     = 1'b1;
            wdata.flags[FL_KILLED] = 1'b1;
            if (ent.state == TS_SLEEP) begin
              wdata.state = TS_READY;
            end
            pid_d = pidarg_q;
          end
          OP_RUN_END: begin
            if (ent.state != TS_RUN) begin
              status_d = STS_BAD_SLOT;
              slot_d   = '0;
              pid_d    = '0;
            end else begin
              we             = 1'b1;
              wdata.run_time = new_run;
              if (nst_q == NS_SLEEP) begin
                wdata.state = TS_SLEEP;
              end else if (nst_q == NS_EXIT) begin
                wdata.state = TS_DONE;
                tat_d       = tat;
                wait_d      = tat - new_run;
                resp_d      = ent.flags[FL_RAN] ? ent.first_run : '1;
                sw_d        = (ent.switches == '0) ? '0 : ent.switches - 31'd1;
              end else begin
                wdata.state = TS_READY;
              end
            end
          end
          OP_WAKE: begin
            if (ent.state == TS_UNUSED) begin
              status_d = STS_BAD_SLOT;
              slot_d   = '0;
              pid_d    = '0;
            end else if (ent.state == TS_SLEEP) begin
              we          = 1'b1;
              wdata.state = TS_READY;
            end
          end
          default: begin
            // free
            if (ent.state != TS_DONE) begin
              status_d = STS_BAD_SLOT;
              slot_d   = '0;
              pid_d    = '0;
            end else begin
              we          = 1'b1;
              wdata.state = TS_UNUSED;
              wdata.pid   = '0;
              wdata.flags = '0;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      found_q   <= 1'b0;
      last_q    <= '1;
      npid_q    <= 31'd1;
      valid_q   <= '0;
      done_o    <= 1'b0;
      run_wt_q  <= 8'd1;
      wait_wt_q <= 8'd13;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      found_q <= found_d;
      last_q  <= last_d;
      npid_q  <= npid_d;
      done_o  <= done_d;
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_RUN_WEIGHT:  run_wt_q  <= cfg_data_i;
          CFG_WAIT_WEIGHT: wait_wt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ridx_q   <= ridx_d;
    best_q   <= best_d;
    bscore_q <= bscore_d;
    tgt_q    <= tgt_d;
    if (re) begin
      vld_q <= valid_q[raddr];
    end
    if (accept) begin
      op_q     <= opcode_i;
      now_q    <= now_tick_i;
      slot_q   <= slot_arg_i;
      pidarg_q <= pid_arg_i;
      defer_q  <= defer_start_i;
      limit_q  <= run_limit_i;
      nst_q    <= next_state_i;
    end
    status_o     <= status_d;
    slot_out_o   <= slot_d;
    pid_out_o    <= pid_d;
    turnaround_o <= tat_d;
    waiting_o    <= wait_d;
    response_o   <= $signed(resp_d);
    switches_o   <= sw_d;
  end

`include "aging_score_task_scheduler_top_assert.svh"

  `ASTS_ASSERT_NXT(a_accept_busy, accept, busy_o, "accepted command did not go busy")
  `ASTS_ASSERT_IMP(a_done_after_busy, done_o, $past(busy_o), "result without a command")
  `ASTS_ASSERT_IMP(a_done_idle, done_o, !busy_o, "still busy with the result out")
  `ASTS_ASSERT_IMP(a_rv_scan, rv_q, (state_q == S_SCAN) || (state_q == S_LAST),
                   "row data outside the sweep")

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asts_pkg::*;

  // How the driver retargets a command at the table contents it is presented against
  localparam logic [2:0] AIM_NONE     = 3'd0;
  localparam logic [2:0] AIM_RUNNING  = 3'd1;
  localparam logic [2:0] AIM_SLEEPING = 3'd2;
  localparam logic [2:0] AIM_DONE     = 3'd3;
  localparam logic [2:0] AIM_PID      = 3'd4;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] now;
    logic [5:0]  slot;
    logic [30:0] pid;
    logic        defer;
    logic [30:0] limit;
    logic [1:0]  nst;
    logic [2:0]  aim;
    logic        drain;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [30:0] pid;
    logic [31:0] tat;
    logic [31:0] wt;
    logic [31:0] resp;
    logic [30:0] sw;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  cmd_t cur = '0;
  logic [3:0] gap = 4'd0;

  logic busy, done, cfg_ready;
  logic [2:0] status;
  logic [5:0] slot_out;
  logic [30:0] pid_out, switches;
  logic [31:0] turnaround, waiting;
  logic signed [31:0] response;

  cmd_t pend_q[$];
  sched_res_t sched_exp_q[$];
  int errors = 0;
  logic [31:0] tick;

  // Shadow task table
  logic [2:0]  t_state[TABLE_ENTRIES];
  logic [30:0] t_pid[TABLE_ENTRIES];
  logic [3:0]  t_flags[TABLE_ENTRIES];
  logic [31:0] t_arr[TABLE_ENTRIES];
  logic [31:0] t_run[TABLE_ENTRIES];
  logic [31:0] t_last[TABLE_ENTRIES];
  logic [31:0] t_first[TABLE_ENTRIES];
  logic [31:0] t_dstart[TABLE_ENTRIES];
  logic [30:0] t_limit[TABLE_ENTRIES];
  logic [30:0] t_sw[TABLE_ENTRIES];
  logic [30:0] pid_ctr = 31'd1;
  logic [31:0] last_disp = 32'hFFFF_FFFF;
  logic [7:0]  run_w = 8'd1;
  logic [7:0]  wait_w = 8'd13;

  always #5 clk = ~clk;

  aging_score_task_scheduler_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .opcode_i(cur.op), .now_tick_i(cur.now), .slot_arg_i(cur.slot), .pid_arg_i(cur.pid),
    .defer_start_i(cur.defer), .run_limit_i(cur.limit), .next_state_i(cur.nst),
    .done_o(done), .status_o(status), .slot_out_o(slot_out), .pid_out_o(pid_out),
    .turnaround_o(turnaround), .waiting_o(waiting), .response_o(response),
    .switches_o(switches), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Scheduler behavior: applies one command to the shadow table, returns its result
  function automatic sched_res_t sched_step(cmd_t c);
    sched_res_t r;
    logic found;
    int best;
    logic [31:0] w, sc, best_sc;
    r = '0;
    found = 1'b0;
    best = 0;
    best_sc = '0;
    case (c.op)
      OP_CREATE: begin
        r.status = STS_FULL;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!found && t_state[i] == TS_UNUSED) begin
            found = 1'b1;
            r.status = STS_OK;
            r.slot = 6'(i);
            r.pid = pid_ctr;
            t_pid[i] = pid_ctr;
            pid_ctr = pid_ctr + 31'd1;
            if (pid_ctr == 31'd0) pid_ctr = 31'd1;
            t_flags[i] = '0;
            t_flags[i][FL_DEFER] = c.defer;
            t_arr[i] = c.now;
            t_run[i] = '0;
            t_last[i] = '0;
            t_first[i] = '0;
            t_dstart[i] = c.now;
            t_limit[i] = c.limit;
            t_sw[i] = '0;
            t_state[i] = c.defer ? TS_DEFER : TS_READY;
          end
        end
      end
      OP_START: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (t_flags[i][FL_DEFER] && t_state[i] == TS_DEFER) begin
            t_state[i] = TS_READY;
            t_dstart[i] = c.now;
          end
        end
      end
      OP_PICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (t_state[i] != TS_READY || t_flags[i][FL_FROZEN]) continue;
          // expired deferral: flag dropped, entry sits out this pick
          if (t_flags[i][FL_DEFER] && t_limit[i] != 0 &&
              (c.now - t_dstart[i]) >= {1'b0, t_limit[i]}) begin
            t_flags[i][FL_DEFER] = 1'b0;
            continue;
          end
          w = c.now - t_arr[i] - t_run[i];
          sc = {24'd0, wait_w} * w - {24'd0, run_w} * t_run[i];
          if (!found || $signed(sc) > $signed(best_sc)) begin
            found = 1'b1;
            best = i;
            best_sc = sc;
          end
        end
        if (!found) r.status = STS_NONE;
        else begin
          if (!t_flags[best][FL_RAN]) begin
            t_first[best] = c.now - t_arr[best];
            t_flags[best][FL_RAN] = 1'b1;
          end
          t_last[best] = c.now;
          if ({1'b0, t_pid[best]} != last_disp && t_sw[best] != PID_MAX)
            t_sw[best] = t_sw[best] + 31'd1;
          if (t_pid[best] != 31'd1 && t_pid[best] != 31'd2) last_disp = {1'b0, t_pid[best]};
          t_state[best] = TS_RUN;
          r.slot = 6'(best);
          r.pid = t_pid[best];
        end
      end
      OP_RUN_END: begin
        if (t_state[c.slot] != TS_RUN) r.status = STS_BAD_SLOT;
        else begin
          t_run[c.slot] = t_run[c.slot] + (c.now - t_last[c.slot]);
          r.slot = c.slot;
          r.pid = t_pid[c.slot];
          if (c.nst == NS_SLEEP) t_state[c.slot] = TS_SLEEP;
          else if (c.nst != NS_EXIT) t_state[c.slot] = TS_READY;
          else begin
            t_state[c.slot] = TS_DONE;
            r.tat = c.now - t_arr[c.slot];
            r.wt = r.tat - t_run[c.slot];
            r.resp = t_flags[c.slot][FL_RAN] ? t_first[c.slot] : 32'hFFFF_FFFF;
            r.sw = (t_sw[c.slot] == 0) ? 31'd0 : t_sw[c.slot] - 31'd1;
          end
        end
      end
      OP_WAKE: begin
        if (t_state[c.slot] == TS_UNUSED) r.status = STS_BAD_SLOT;
        else begin
          if (t_state[c.slot] == TS_SLEEP) t_state[c.slot] = TS_READY;
          r.slot = c.slot;
          r.pid = t_pid[c.slot];
        end
      end
      OP_FREEZE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (t_pid[i] > 31'd2) t_flags[i][FL_FROZEN] = 1'b1;
      end
      OP_UNFREEZE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) t_flags[i][FL_FROZEN] = 1'b0;
      end
      OP_KILL: begin
        r.status = STS_NO_PID;
        if (c.pid != 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!found && t_state[i] != TS_UNUSED && t_pid[i] == c.pid) begin
              found = 1'b1;
              t_flags[i][FL_KILLED] = 1'b1;
              if (t_state[i] == TS_SLEEP) t_state[i] = TS_READY;
              r.status = STS_OK;
              r.slot = 6'(i);
              r.pid = c.pid;
            end
          end
        end
      end
      OP_FREE: begin
        if (t_state[c.slot] != TS_DONE) r.status = STS_BAD_SLOT;
        else begin
          r.slot = c.slot;
          r.pid = t_pid[c.slot];
          t_state[c.slot] = TS_UNUSED;
          t_pid[c.slot] = '0;
          t_flags[c.slot] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Point a command at a live entry of the wanted kind, if one exists
  function automatic cmd_t aim_cmd(cmd_t c);
    int hits[$];
    int k;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      case (c.aim)
        AIM_RUNNING:  if (t_state[i] == TS_RUN) hits.push_back(i);
        AIM_SLEEPING: if (t_state[i] == TS_SLEEP) hits.push_back(i);
        AIM_DONE:     if (t_state[i] == TS_DONE) hits.push_back(i);
        AIM_PID:      if (t_state[i] != TS_UNUSED) hits.push_back(i);
        default: ;
      endcase
    end
    if (hits.size() > 0) begin
      k = hits[$urandom_range(0, hits.size() - 1)];
      c.slot = 6'(k);
      if (c.aim == AIM_PID) c.pid = t_pid[k];
    end
    return c;
  endfunction

  // Command driver: one transfer per start/!busy edge, random gap after each
  always @(posedge clk or negedge rst_n) begin : driver
    cmd_t c;
    int wait_n;
    if (!rst_n) begin
      start <= 1'b0;
      gap <= '0;
    end else begin
      wait_n = gap;
      if (start && !busy) begin
        sched_exp_q.push_back(sched_step(cur));
        wait_n = $urandom_range(0, 1) ? $urandom_range(0, 8) : 0;
      end
      if (start && busy) begin
        // hold the command until taken
      end else if (wait_n != 0) begin
        start <= 1'b0;
        gap <= 4'(wait_n - 1);
      end else if (pend_q.size() > 0 &&
                   !(pend_q[0].drain && sched_exp_q.size() != 0)) begin
        c = pend_q.pop_front();
        cur <= aim_cmd(c);
        start <= 1'b1;
        gap <= '0;
      end else begin
        start <= 1'b0;
        gap <= '0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result monitor: every done strobe is one transfer
  always @(posedge clk) begin : monitor
    sched_res_t e;
    if (rst_n && done) begin
      if (sched_exp_q.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual status %h pid %h",
                 $time, status, pid_out);
        errors++;
      end else begin
        e = sched_exp_q.pop_front();
        check_field("status", e.status, status);
        check_field("slot", e.slot, slot_out);
        check_field("pid", e.pid, pid_out);
        check_field("turnaround", e.tat, turnaround);
        check_field("waiting", e.wt, waiting);
        check_field("response", e.resp, response);
        check_field("switches", e.sw, switches);
      end
    end
  end

  task automatic push_cmd(logic [3:0] op, logic [5:0] slot, logic [30:0] pid, logic defer,
                          logic [30:0] limit, logic [1:0] nst, logic [2:0] aim, bit drain);
    cmd_t c;
    tick = tick + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 5000) : $urandom_range(0, 40));
    c = '{op: op, now: tick, slot: slot, pid: pid, defer: defer, limit: limit, nst: nst,
          aim: aim, drain: drain};
    pend_q.push_back(c);
  endtask

  task automatic push_random(bit drain);
    int k;
    logic [30:0] lim;
    k = $urandom_range(0, 99);
    lim = ($urandom_range(0, 2) == 0) ? 31'd0 :
          ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 60));
    if (k < 14)
      push_cmd(OP_CREATE, 6'($urandom), 31'($urandom), 1'($urandom), lim, 2'($urandom),
               AIM_NONE, drain);
    else if (k < 20) push_cmd(OP_START, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), AIM_NONE, drain);
    else if (k < 42) push_cmd(OP_PICK, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), AIM_NONE, drain);
    else if (k < 64) push_cmd(OP_RUN_END, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), ($urandom_range(0, 9) != 0) ? AIM_RUNNING : AIM_NONE,
                              drain);
    else if (k < 71) push_cmd(OP_WAKE, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), ($urandom_range(0, 3) != 0) ? AIM_SLEEPING :
                              AIM_PID, drain);
    else if (k < 74) push_cmd(OP_FREEZE, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), AIM_NONE, drain);
    else if (k < 79) push_cmd(OP_UNFREEZE, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), AIM_NONE, drain);
    else if (k < 87) push_cmd(OP_KILL, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), ($urandom_range(0, 3) != 0) ? AIM_PID : AIM_NONE,
                              drain);
    else if (k < 97) push_cmd(OP_FREE, 6'($urandom), 31'($urandom), 1'($urandom), lim,
                              2'($urandom), ($urandom_range(0, 4) != 0) ? AIM_DONE : AIM_NONE,
                              drain);
    else push_cmd(4'($urandom_range(9, 15)), 6'($urandom), 31'($urandom), 1'($urandom), lim,
                  2'($urandom), AIM_NONE, drain);
  endtask

  // Register write on the config channel, only while the block is idle
  task automatic cfg_write(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_RUN_WEIGHT) run_w = val;
    else wait_w = val;
  endtask

  task automatic drain_all();
    wait (pend_q.size() == 0 && sched_exp_q.size() == 0 && !start);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] rw_set[6];
    logic [7:0] ww_set[6];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      t_state[i] = TS_UNUSED;
      t_pid[i] = '0;
      t_flags[i] = '0;
    end
    tick = 32'd100;
    rw_set = '{8'd1, 8'd0, 8'd255, 8'd255, 8'd0, 8'($urandom)};
    ww_set = '{8'd13, 8'd0, 8'd255, 8'd0, 8'd255, 8'($urandom)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_RUN_WEIGHT, rw_set[ph]);
      cfg_write(CFG_WAIT_WEIGHT, ww_set[ph]);
      if (ph == 0) begin
        // directed: each opcode, edge values and the odd corners
        push_cmd(OP_CREATE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_CREATE, 6'd0, 31'd0, 1'b1, 31'd1, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_CREATE, 6'd0, 31'd0, 1'b1, PID_MAX, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_CREATE, 6'd63, PID_MAX, 1'b1, 31'd0, 2'd3, AIM_NONE, 1'b0);
        push_cmd(OP_PICK, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_START, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_PICK, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_RUN_END, 6'd0, 31'd0, 1'b0, 31'd0, NS_SLEEP, AIM_RUNNING, 1'b0);
        push_cmd(OP_WAKE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_SLEEPING, 1'b0);
        push_cmd(OP_WAKE, 6'd63, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_WAKE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_PICK, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_RUN_END, 6'd0, 31'd0, 1'b0, 31'd0, 2'd3, AIM_RUNNING, 1'b0);
        push_cmd(OP_PICK, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_RUN_END, 6'd0, 31'd0, 1'b0, 31'd0, NS_EXIT, AIM_RUNNING, 1'b0);
        push_cmd(OP_FREE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_DONE, 1'b0);
        push_cmd(OP_FREE, 6'd50, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_RUN_END, 6'd50, 31'd0, 1'b0, 31'd0, NS_EXIT, AIM_NONE, 1'b0);
        push_cmd(OP_KILL, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_KILL, 6'd0, PID_MAX, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_KILL, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_PID, 1'b0);
        push_cmd(OP_FREEZE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_PICK, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(OP_UNFREEZE, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(4'd9, 6'd0, 31'd0, 1'b0, 31'd0, 2'd0, AIM_NONE, 1'b0);
        push_cmd(4'd15, 6'h3F, PID_MAX, 1'b1, PID_MAX, 2'd3, AIM_NONE, 1'b0);
      end
      if (ph == 2) tick = 32'hFFFF_F000;
      else if (ph == 4) tick = $urandom;
      // the first and the sixty-first random command of a phase wait for all results
      for (int n = 0; n < 105; n++) push_random(n == 0 || n == 60);
      drain_all();
    end

    repeat (80) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
`default_nettype wire
